// ===== design/vsrt_pkg.sv =====
// shared types, register codes and constants for the vertex scale/rotate/translate unit
// no dependencies

package vsrt_pkg;

	localparam int MAT_W      = 19;
	localparam int ATAN_STEPS = 24;

	typedef logic signed [MAT_W-1:0] mat_entry_t;
	typedef mat_entry_t [8:0] mat_t;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic               last_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] moved_x;
		logic signed [31:0] moved_y;
		logic signed [31:0] moved_z;
		logic               overflow;
		logic               last_out;
	} result_t;

	typedef enum logic [2:0] {
		REG_ANGLES  = 3'd0,
		REG_SCALE_X = 3'd1,
		REG_SCALE_Y = 3'd2,
		REG_SCALE_Z = 3'd3,
		REG_SHIFT_X = 3'd4,
		REG_SHIFT_Y = 3'd5,
		REG_SHIFT_Z = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_START,
		ST_CORDIC,
		ST_FINISH,
		ST_MATRIX,
		ST_READY
	} bld_state_t;

	typedef enum logic [3:0] {
		OP_SX, OP_CX, OP_SY, OP_CY, OP_SZ, OP_CZ, OP_SXSY, OP_CXSY, OP_ONE
	} opsel_t;

	typedef enum logic [1:0] {
		DST_T, DST_SXSY, DST_CXSY, DST_MAT
	} dst_t;

	typedef struct packed {
		opsel_t     a;
		opsel_t     b;
		logic       neg;
		logic       add_t;
		dst_t       dst;
		logic [3:0] idx;
	} mstep_t;

	localparam logic [3:0] LAST_STEP = 4'd14;
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	function automatic logic [31:0] atan_f(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// one product per step: dst = (neg ? -a*b : a*b) + (add_t ? t : 0)
	function automatic mstep_t mstep_f(input logic [3:0] s);
		mstep_t m;
		unique case (s)
			4'd0:  m = '{OP_SX,   OP_SY,  1'b0, 1'b0, DST_SXSY, 4'd0};
			4'd1:  m = '{OP_CX,   OP_SY,  1'b0, 1'b0, DST_CXSY, 4'd0};
			4'd2:  m = '{OP_CY,   OP_CZ,  1'b0, 1'b0, DST_MAT,  4'd0};
			4'd3:  m = '{OP_CX,   OP_SZ,  1'b1, 1'b0, DST_T,    4'd0};
			4'd4:  m = '{OP_SXSY, OP_CZ,  1'b0, 1'b1, DST_MAT,  4'd1};
			4'd5:  m = '{OP_SX,   OP_SZ,  1'b0, 1'b0, DST_T,    4'd0};
			4'd6:  m = '{OP_CXSY, OP_CZ,  1'b0, 1'b1, DST_MAT,  4'd2};
			4'd7:  m = '{OP_CY,   OP_SZ,  1'b0, 1'b0, DST_MAT,  4'd3};
			4'd8:  m = '{OP_CX,   OP_CZ,  1'b0, 1'b0, DST_T,    4'd0};
			4'd9:  m = '{OP_SXSY, OP_SZ,  1'b0, 1'b1, DST_MAT,  4'd4};
			4'd10: m = '{OP_SX,   OP_CZ,  1'b1, 1'b0, DST_T,    4'd0};
			4'd11: m = '{OP_CXSY, OP_SZ,  1'b0, 1'b1, DST_MAT,  4'd5};
			4'd12: m = '{OP_SY,   OP_ONE, 1'b1, 1'b0, DST_MAT,  4'd6};
			4'd13: m = '{OP_SX,   OP_CY,  1'b0, 1'b0, DST_MAT,  4'd7};
			4'd14: m = '{OP_CX,   OP_CY,  1'b0, 1'b0, DST_MAT,  4'd8};
			default: m = '{OP_ONE, OP_ONE, 1'b0, 1'b0, DST_T,   4'd0};
		endcase
		return m;
	endfunction

endpackage

// ===== design/vsrt_matrix.sv =====
// rotation matrix builder: shared cordic for the three angles, then one product per cycle
// depends on vsrt_pkg

module vsrt_matrix #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          restart,
	input  logic [47:0]   angles,
	output vsrt_pkg::mat_t mat,
	output logic          ready
);
	import vsrt_pkg::*;

	localparam int NIT = (TRIG_ITERATIONS < ATAN_STEPS) ? TRIG_ITERATIONS : ATAN_STEPS;
	localparam logic [4:0] LAST_IT = 5'(NIT - 1);

	bld_state_t state_q, state_nxt;
	logic [1:0] ang_q;
	logic [4:0] it_q;
	logic [3:0] step_q;
	logic signed [32:0] x_q, y_q, z_q;
	logic neg_q;
	mat_entry_t sin_q [3];
	mat_entry_t cos_q [3];
	mat_entry_t sxsy_q, cxsy_q, t_q;
	mat_t mat_q;

	logic [15:0] a16;
	logic signed [32:0] z0, z_fold;
	logic fold;
	logic signed [32:0] xs, ys, xn, yn, zn;
	logic signed [32:0] xf, yf;
	logic signed [18:0] cos_r, sin_r;
	mstep_t ms;
	mat_entry_t opa, opb, pres;
	logic signed [37:0] prod;
	logic signed [21:0] prnd;

	function automatic logic signed [18:0] rclamp(input logic signed [32:0] v);
		logic signed [32:0] r;
		r = (v + 33'sd8192) >>> 14;
		if (r > 33'sd65536)       return 19'sd65536;
		else if (r < -33'sd65536) return -19'sd65536;
		else                      return r[18:0];
	endfunction

	always_comb begin
		unique case (ang_q)
			2'd0:    a16 = angles[15:0];
			2'd1:    a16 = angles[31:16];
			default: a16 = angles[47:32];
		endcase
		z0 = 33'(signed'({a16, 16'h0000}));
		fold = 1'b0;
		z_fold = z0;
		if (z0 > 33'sd1073741824) begin
			z_fold = z0 - 33'sd2147483648;
			fold = 1'b1;
		end else if (z0 < -33'sd1073741824) begin
			z_fold = z0 + 33'sd2147483648;
			fold = 1'b1;
		end
	end

	always_comb begin
		xs = x_q >>> it_q;
		ys = y_q >>> it_q;
		if (!z_q[32]) begin
			xn = x_q - ys;
			yn = y_q + xs;
			zn = z_q - 33'(atan_f(it_q));
		end else begin
			xn = x_q + ys;
			yn = y_q - xs;
			zn = z_q + 33'(atan_f(it_q));
		end
		xf = neg_q ? -x_q : x_q;
		yf = neg_q ? -y_q : y_q;
		cos_r = rclamp(xf);
		sin_r = rclamp(yf);
	end

	function automatic mat_entry_t pick(input opsel_t o, input mat_entry_t sx, input mat_entry_t cx,
			input mat_entry_t sy, input mat_entry_t cy, input mat_entry_t sz,
			input mat_entry_t cz, input mat_entry_t sxsy, input mat_entry_t cxsy);
		mat_entry_t r;
		unique case (o)
			OP_SX:   r = sx;
			OP_CX:   r = cx;
			OP_SY:   r = sy;
			OP_CY:   r = cy;
			OP_SZ:   r = sz;
			OP_CZ:   r = cz;
			OP_SXSY: r = sxsy;
			OP_CXSY: r = cxsy;
			default: r = 19'sd65536;
		endcase
		return r;
	endfunction

	always_comb begin
		ms = mstep_f(step_q);
		opa = pick(ms.a, sin_q[0], cos_q[0], sin_q[1], cos_q[1], sin_q[2], cos_q[2],
			sxsy_q, cxsy_q);
		opb = pick(ms.b, sin_q[0], cos_q[0], sin_q[1], cos_q[1], sin_q[2], cos_q[2],
			sxsy_q, cxsy_q);
		prod = 38'(opa) * 38'(opb);
		prnd = 22'((prod + 38'sd32768) >>> 16);
		pres = (ms.neg ? -prnd[18:0] : prnd[18:0]) + (ms.add_t ? t_q : 19'sd0);
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_START:  state_nxt = ST_CORDIC;
			ST_CORDIC: if (it_q == LAST_IT) state_nxt = ST_FINISH;
			ST_FINISH: state_nxt = (ang_q == 2'd2) ? ST_MATRIX : ST_START;
			ST_MATRIX: if (step_q == LAST_STEP) state_nxt = ST_READY;
			ST_READY:  state_nxt = ST_READY;
			default:   state_nxt = ST_START;
		endcase
		if (restart) state_nxt = ST_START;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			ang_q   <= 2'd0;
			it_q    <= 5'd0;
			step_q  <= 4'd0;
		end else begin
			state_q <= state_nxt;
			if (restart) begin
				ang_q <= 2'd0;
			end else begin
				unique case (state_q)
					ST_START:  it_q <= 5'd0;
					ST_CORDIC: it_q <= it_q + 5'd1;
					ST_FINISH: begin
						ang_q  <= (ang_q == 2'd2) ? 2'd0 : ang_q + 2'd1;
						step_q <= 4'd0;
					end
					ST_MATRIX: step_q <= step_q + 4'd1;
					default:   ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_START: begin
				x_q   <= CORDIC_GAIN;
				y_q   <= '0;
				z_q   <= z_fold;
				neg_q <= fold;
			end
			ST_CORDIC: begin
				x_q <= xn;
				y_q <= yn;
				z_q <= zn;
			end
			ST_FINISH: begin
				sin_q[ang_q] <= sin_r;
				cos_q[ang_q] <= cos_r;
			end
			ST_MATRIX: begin
				unique case (ms.dst)
					DST_T:    t_q    <= pres;
					DST_SXSY: sxsy_q <= pres;
					DST_CXSY: cxsy_q <= pres;
					default:  mat_q[ms.idx] <= pres;
				endcase
			end
			default: ;
		endcase
	end

	assign mat   = mat_q;
	assign ready = (state_q == ST_READY);

endmodule

// ===== design/vertex_scale_rotate_translate_unit.sv =====
// requests pass a 4-stage pipeline to result valid; one vertex per cycle sustained while
// in_stall is low (stages: scale multiply, rotate multiplies, row sum, translate)
// after reset or any register write the matrix is rebuilt by one shared cordic and one
// multiplier (cordic iterations capped at 24), in_stall high meanwhile
// reset clears the valid bits, loads the register defaults and starts a matrix rebuild
// depends on vsrt_pkg and vsrt_matrix

module vertex_scale_rotate_translate_unit #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  vsrt_pkg::vertex_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output vsrt_pkg::result_t out_data,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [47:0]       cfg_data
);
	import vsrt_pkg::*;

	logic [47:0] angles_q;
	logic signed [15:0] scale_q [3];
	logic signed [31:0] shift_q [3];
	logic restart;
	mat_t mat;
	logic ready;

	logic en, acc;
	logic v_s1, v_s2, v_s3, v_s4;
	logic last_s1, last_s2, last_s3;
	logic signed [47:0] prod_s1 [3];
	logic signed [54:0] p_s2 [9];
	logic signed [40:0] row_s3 [3];
	result_t out_s4;

	logic signed [35:0] scaled [3];
	logic signed [31:0] vin [3];
	logic signed [31:0] sat [3];
	logic ovf [3];

	always_comb begin
		restart = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				REG_ANGLES, REG_SCALE_X, REG_SCALE_Y, REG_SCALE_Z,
				REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z: restart = 1'b1;
				default: restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angles_q <= '0;
			for (int i = 0; i < 3; i++) begin
				scale_q[i] <= 16'sd4096;
				shift_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ANGLES:  angles_q   <= cfg_data;
				REG_SCALE_X: scale_q[0] <= cfg_data[15:0];
				REG_SCALE_Y: scale_q[1] <= cfg_data[15:0];
				REG_SCALE_Z: scale_q[2] <= cfg_data[15:0];
				REG_SHIFT_X: shift_q[0] <= cfg_data[31:0];
				REG_SHIFT_Y: shift_q[1] <= cfg_data[31:0];
				REG_SHIFT_Z: shift_q[2] <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	vsrt_matrix #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.angles  (angles_q),
		.mat     (mat),
		.ready   (ready)
	);

	// whole pipeline advances together unless the output holds a stalled result
	assign en       = !v_s4 || !out_stall;
	assign in_stall = !en || !ready;
	assign acc      = in_valid && !in_stall;

	assign vin[0] = in_data.vertex_x;
	assign vin[1] = in_data.vertex_y;
	assign vin[2] = in_data.vertex_z;

	always_comb begin
		for (int i = 0; i < 3; i++)
			scaled[i] = 36'((prod_s1[i] + 48'sd2048) >>> 12);
	end

	always_comb begin
		logic signed [41:0] tot;
		for (int r = 0; r < 3; r++) begin
			tot = 42'(row_s3[r]) + 42'(shift_q[r]);
			if (tot > 42'sd2147483647) begin
				sat[r] = 32'sh7fffffff;
				ovf[r] = 1'b1;
			end else if (tot < -42'sd2147483648) begin
				sat[r] = 32'sh80000000;
				ovf[r] = 1'b1;
			end else begin
				sat[r] = tot[31:0];
				ovf[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				prod_s1[i] <= 48'(vin[i]) * 48'(scale_q[i]);
			last_s1 <= in_data.last_vertex;

			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					p_s2[r*3+c] <= 55'($signed(mat[r*3+c])) * 55'(scaled[c]);
			last_s2 <= last_s1;

			for (int r = 0; r < 3; r++)
				row_s3[r] <= 41'((57'(p_s2[r*3]) + 57'(p_s2[r*3+1]) + 57'(p_s2[r*3+2])
					+ 57'sd32768) >>> 16);
			last_s3 <= last_s2;

			out_s4.moved_x  <= sat[0];
			out_s4.moved_y  <= sat[1];
			out_s4.moved_z  <= sat[2];
			out_s4.overflow <= ovf[0] | ovf[1] | ovf[2];
			out_s4.last_out <= last_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = out_s4;

endmodule
